@@ hw/rtl/mts_pkg.sv @@
// shared types and constants for the max-tracking stack
// used by max_tracking_stack_core and the testbench; no dependencies
`default_nettype none

package mts_pkg;

   // stack geometry
   localparam int unsigned STACK_DEPTH = 1024;
   localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

   // fixed payload widths
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COUNT_OUT_W = 11;
   localparam int unsigned MAXIMA_W    = VALUE_W + CNT_W;

   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [VALUE_W-1:0]     value_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;

   localparam cnt_type DEPTH_CNT = cnt_type'(STACK_DEPTH);

   // operation codes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // error codes
   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   // result of one transaction
   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      logic signed [VALUE_W-1:0] max_value;
      logic                      is_empty;
      count_out_type             stored_count;
      err_type                   error_code;
   } res_type;

endpackage

`default_nettype wire

@@ hw/rtl/mts_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// standalone; used for the value and maxima stores
`default_nettype none

module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/max_tracking_stack_core.sv @@
// max-tracking lifo stack: value store and counted maxima store in ram
// depends on mts_pkg and mts_ram
`default_nettype none

// Usage
//   req channel: one transaction is a push (req_tuser = push) of req_tdata or
//   a pop (req_tuser = pop, req_tdata ignored).
//   rsp channel: one transaction per request with the popped value, the
//   current maximum, the empty flag, the entry count and an error code.
//   Pop on empty and push on full leave the stack unchanged and are flagged.
// Timing
//   An item is taken in the idle state only: the accept cycle updates the cached top
//   entries and writes the stores, the next cycle takes the ram read of the
//   entry below the top that a pop exposes. rsp_tvalid rises at the same edge
//   where req_tready comes back, so the next item is taken only after that.
//   A finished response waits in the output register; one more request is
//   still taken, its result is held and req_tready stays low until the
//   output register frees up.
// Reset
//   Synchronous reset empties the stack; ram contents are not cleared and
//   need no clearing pass, since only written entries are ever read.

module max_tracking_stack_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] push_value
   input  wire logic [0:0]  req_tuser,   // [0] operation
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [31:0] popped_value, [63:32] max_value,
                                         // [64] is_empty, [75:65] stored_count, zero fill
   output logic [1:0]       rsp_tuser    // [1:0] error_code
);

   mts_pkg::state_type state_ff, state_in;

   // cached top entries
   mts_pkg::cnt_type   count_ff, count_in;
   mts_pkg::value_type top_val_ff, top_val_in;
   mts_pkg::cnt_type   mtop_ff, mtop_in;
   mts_pkg::value_type mval_ff, mval_in;
   mts_pkg::cnt_type   mcnt_ff, mcnt_in;
   logic               reload_v_ff, reload_v_in;
   logic               reload_m_ff, reload_m_in;

   // pending result and output register
   mts_pkg::res_type   res_ff, res_in;
   mts_pkg::res_type   out_ff, out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // ram ports
   logic                            v_we;
   mts_pkg::addr_type               v_waddr, v_raddr;
   mts_pkg::value_type              v_wdata, v_rdata;
   logic                            m_we;
   mts_pkg::addr_type               m_waddr, m_raddr;
   logic [mts_pkg::MAXIMA_W-1:0]    m_wdata, m_rdata;

   logic               accept;
   logic               out_free;
   mts_pkg::op_type    op;
   mts_pkg::value_type val;
   mts_pkg::value_type max_now;
   mts_pkg::cnt_type   mcnt_dec;
   mts_pkg::res_type   res_now;

   assign req_tready = (state_ff == mts_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign op         = mts_pkg::op_type'(req_tuser[0]);
   assign val        = req_tdata;
   assign mcnt_dec   = mcnt_ff - mts_pkg::cnt_type'(1);

   mts_ram #(
      .WIDTH (mts_pkg::VALUE_W),
      .DEPTH (mts_pkg::STACK_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   mts_ram #(
      .WIDTH (mts_pkg::MAXIMA_W),
      .DEPTH (mts_pkg::STACK_DEPTH)
   ) u_maxima_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   // maximum after the operation, using reloaded maxima entry if any
   assign max_now = (mtop_ff == '0) ? '0 :
                    (reload_m_ff ? m_rdata[mts_pkg::MAXIMA_W-1 -: mts_pkg::VALUE_W] : mval_ff);

   always_comb begin
      res_now           = res_ff;
      res_now.max_value = max_now;
   end

   // accept cycle: update caches, write back to ram, launch reloads; reload cycle: take the exposed entries
   always_comb begin
      count_in    = count_ff;
      top_val_in  = top_val_ff;
      mtop_in     = mtop_ff;
      mval_in     = mval_ff;
      mcnt_in     = mcnt_ff;
      reload_v_in = 1'b0;
      reload_m_in = 1'b0;
      res_in      = res_ff;
      v_we        = 1'b0;
      v_waddr     = count_ff[mts_pkg::ADDR_W-1:0];
      v_wdata     = val;
      v_raddr     = mts_pkg::addr_type'(count_ff - mts_pkg::cnt_type'(2));
      m_we        = 1'b0;
      m_waddr     = mts_pkg::addr_type'(mtop_ff - mts_pkg::cnt_type'(1));
      m_wdata     = {mval_ff, mcnt_ff};
      m_raddr     = mts_pkg::addr_type'(mtop_ff - mts_pkg::cnt_type'(2));

      if (accept) begin
         res_in.popped_value = '0;
         res_in.max_value    = '0;
         res_in.error_code   = mts_pkg::ERR_OK;
         unique case (op)
            mts_pkg::OP_PUSH: begin
               if (count_ff >= mts_pkg::DEPTH_CNT) begin
                  res_in.error_code = mts_pkg::ERR_FULL;
               end else begin
                  v_we       = 1'b1;
                  top_val_in = val;
                  count_in   = count_ff + mts_pkg::cnt_type'(1);
                  // maxima stack update
                  priority if (mtop_ff == '0) begin
                     m_we    = 1'b1;
                     m_waddr = '0;
                     m_wdata = {val, mts_pkg::cnt_type'(1)};
                     mval_in = val;
                     mcnt_in = mts_pkg::cnt_type'(1);
                     mtop_in = mts_pkg::cnt_type'(1);
                  end else if (val == mval_ff) begin
                     m_we    = 1'b1;
                     mcnt_in = mcnt_ff + mts_pkg::cnt_type'(1);
                     m_wdata = {mval_ff, mcnt_ff + mts_pkg::cnt_type'(1)};
                  end else if ($signed(val) > $signed(mval_ff) &&
                               mtop_ff < mts_pkg::DEPTH_CNT) begin
                     m_we    = 1'b1;
                     m_waddr = mtop_ff[mts_pkg::ADDR_W-1:0];
                     m_wdata = {val, mts_pkg::cnt_type'(1)};
                     mval_in = val;
                     mcnt_in = mts_pkg::cnt_type'(1);
                     mtop_in = mtop_ff + mts_pkg::cnt_type'(1);
                  end else begin
                     m_we = 1'b0;
                  end
               end
            end
            mts_pkg::OP_POP: begin
               if (count_ff == '0) begin
                  res_in.error_code = mts_pkg::ERR_EMPTY;
               end else begin
                  res_in.popped_value = top_val_ff;
                  count_in    = count_ff - mts_pkg::cnt_type'(1);
                  reload_v_in = (count_ff >= mts_pkg::cnt_type'(2));
                  // popping the current maximum
                  if (mtop_ff != '0 && top_val_ff == mval_ff) begin
                     if (mcnt_ff <= mts_pkg::cnt_type'(1)) begin
                        mtop_in     = mtop_ff - mts_pkg::cnt_type'(1);
                        reload_m_in = (mtop_ff >= mts_pkg::cnt_type'(2));
                     end else begin
                        m_we    = 1'b1;
                        m_wdata = {mval_ff, mcnt_dec};
                        mcnt_in = mcnt_dec;
                     end
                  end
               end
            end
            default: begin
               res_in.error_code = mts_pkg::ERR_OK;
            end
         endcase
         res_in.is_empty     = (count_in == '0);
         res_in.stored_count = mts_pkg::count_out_type'(count_in);
      end else if (state_ff == mts_pkg::ST_LOAD) begin
         // take the exposed entries from ram
         if (reload_v_ff) begin
            top_val_in = v_rdata;
         end
         if (reload_m_ff) begin
            mval_in = m_rdata[mts_pkg::MAXIMA_W-1 -: mts_pkg::VALUE_W];
            mcnt_in = m_rdata[mts_pkg::CNT_W-1:0];
         end
         res_in.max_value = max_now;
      end
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mts_pkg::ST_LOAD;
            end
         end
         mts_pkg::ST_LOAD: begin
            if (out_free) begin
               out_in       = res_now;
               rsp_valid_in = 1'b1;
               state_in     = mts_pkg::ST_IDLE;
            end else begin
               state_in = mts_pkg::ST_WAIT;
            end
         end
         mts_pkg::ST_WAIT: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = mts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_IDLE;
         count_ff     <= '0;
         mtop_ff      <= '0;
         reload_v_ff  <= 1'b0;
         reload_m_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mtop_ff      <= mtop_in;
         reload_v_ff  <= reload_v_in;
         reload_m_ff  <= reload_m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      mval_ff    <= mval_in;
      mcnt_ff    <= mcnt_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.stored_count, out_ff.is_empty,
                        out_ff.max_value, out_ff.popped_value};
   assign rsp_tuser  = out_ff.error_code;

   // maxima stack never deeper than the value stack
   assert property (@(posedge clock) disable iff (reset)
      mtop_ff <= count_ff)
      else $error("maxima stack deeper than value stack");

   // maxima stack empty exactly when the value stack is empty
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (mtop_ff == '0))
      else $error("maxima stack emptiness disagrees with value stack");

   // count never beyond the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= mts_pkg::DEPTH_CNT)
      else $error("entry count beyond stack depth");

   // cached top maximum always has a live count when idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mts_pkg::ST_IDLE && mtop_ff != '0) |-> (mcnt_ff != '0))
      else $error("top maximum entry with zero count");

   // an accepted transaction always goes to the reload cycle next
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == mts_pkg::ST_LOAD))
      else $error("accepted transaction skipped the reload cycle");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for max_tracking_stack_core: pushes and pops over the
// stream ports, a shadow stack predicts every response; depends on mts_pkg
`timescale 1ns / 100ps

module tb;

   localparam int unsigned RANDOM_ITEMS = 540;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 400_000;

   // shadow of the stack and its counted maxima, plus the responses still owed
   class max_stack_shadow;
      mts_pkg::value_type   values[mts_pkg::STACK_DEPTH];
      mts_pkg::value_type   peak_vals[mts_pkg::STACK_DEPTH];
      mts_pkg::cnt_type     peak_hits[mts_pkg::STACK_DEPTH];
      int unsigned          depth_n;
      int unsigned          peaks_n;
      mts_pkg::res_type     pending_results[$];
      int unsigned          errors;
      int unsigned          n_checked;
      int unsigned          n_push;
      int unsigned          n_full;
      int unsigned          n_pop;
      int unsigned          n_empty;
      int unsigned          deepest;
      int unsigned          most_peaks;

      function new();
         depth_n    = 0;
         peaks_n    = 0;
         errors     = 0;
         n_checked  = 0;
         n_push     = 0;
         n_full     = 0;
         n_pop      = 0;
         n_empty    = 0;
         deepest    = 0;
         most_peaks = 0;
      endfunction

      function mts_pkg::value_type current_max();
         return (peaks_n > 0) ? peak_vals[peaks_n-1] : '0;
      endfunction

      // one accepted request transaction: update the shadow, queue the response
      function void note_request(mts_pkg::op_type op, mts_pkg::value_type data);
         mts_pkg::res_type r;
         r = '0;
         r.error_code = mts_pkg::ERR_OK;
         if (op == mts_pkg::OP_PUSH) begin
            n_push++;
            if (depth_n >= mts_pkg::STACK_DEPTH) begin
               r.error_code = mts_pkg::ERR_FULL;
               n_full++;
            end else begin
               values[depth_n] = data;
               depth_n++;
               if (peaks_n == 0) begin
                  peak_vals[0] = data;
                  peak_hits[0] = 1;
                  peaks_n      = 1;
               end else if (data == peak_vals[peaks_n-1]) begin
                  peak_hits[peaks_n-1]++;
               end else if ($signed(data) > $signed(peak_vals[peaks_n-1]) &&
                            peaks_n < mts_pkg::STACK_DEPTH) begin
                  peak_vals[peaks_n] = data;
                  peak_hits[peaks_n] = 1;
                  peaks_n++;
               end
            end
         end else begin
            n_pop++;
            if (depth_n == 0) begin
               r.error_code = mts_pkg::ERR_EMPTY;
               n_empty++;
            end else begin
               depth_n--;
               r.popped_value = values[depth_n];
               // popping the top maximum uses up one of its pushes
               if (peaks_n > 0 && values[depth_n] == peak_vals[peaks_n-1]) begin
                  if (peak_hits[peaks_n-1] > 0)
                     peak_hits[peaks_n-1]--;
                  if (peak_hits[peaks_n-1] == 0)
                     peaks_n--;
               end
            end
         end
         r.max_value    = current_max();
         r.is_empty     = (depth_n == 0);
         r.stored_count = mts_pkg::count_out_type'(depth_n);
         if (depth_n > deepest)
            deepest = depth_n;
         if (peaks_n > most_peaks)
            most_peaks = peaks_n;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // one accepted response transaction against the oldest prediction
      function void check_response(logic [79:0] tdata, logic [1:0] tuser);
         mts_pkg::res_type e;
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction: tdata 0x%020h tuser %0d", tdata, tuser);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         n_checked++;
         compare_field("popped_value", e.popped_value, tdata[31:0]);
         compare_field("max_value", e.max_value, tdata[63:32]);
         compare_field("is_empty", 32'(e.is_empty), 32'(tdata[64]));
         compare_field("stored_count", 32'(e.stored_count), 32'(tdata[75:65]));
         compare_field("zero fill", '0, 32'(tdata[79:76]));
         compare_field("error_code", 32'(e.error_code), 32'(tuser));
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [31:0] push_value
   logic [0:0]  req_tuser  = '0;     // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // [31:0] popped_value, [63:32] max_value,
                                     // [64] is_empty, [75:65] stored_count, zero fill
   logic [1:0]  rsp_tuser;           // [1:0] error_code

   max_stack_shadow shadow = new();
   bit              hold_active = 1'b0;
   int unsigned     burst_left  = 0;
   int unsigned     gap_pct     = 25;
   int unsigned     cycles      = 0;

   max_tracking_stack_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_response(rsp_tdata, rsp_tuser);
   end

   // receiver: random stall patterns, one long hold-off
   initial begin : receiver
      int unsigned mode;
      int unsigned left;
      int unsigned phase;
      bit          held;
      mode  = 0;
      left  = 0;
      phase = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && shadow.n_checked >= 150) begin
            // long hold-off while the sender keeps offering
            held        = 1'b1;
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(32, 300);
            end
            left--;
            phase++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= ($urandom_range(0, 6) == 0);
               default: rsp_tready <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // offer one request transaction and wait for it to be taken
   task automatic send_item(input mts_pkg::op_type op, input mts_pkg::value_type data);
      int unsigned gap;
      if (burst_left == 0) begin
         if (!hold_active && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_request(op, data);
   endtask

   // push random values, small values around zero, the current maximum, just above or below it, and extremes
   function automatic mts_pkg::value_type pick_value();
      mts_pkg::value_type top_max;
      top_max = shadow.current_max();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return mts_pkg::value_type'($urandom_range(0, 6)) - 32'd3;
         6:          return top_max;
         7:          return top_max + 32'd1;
         8:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default:    return top_max - mts_pkg::value_type'($urandom_range(1, 3));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned seg_len;
      int unsigned push_pct;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pops, extremes, repeated maxima, smaller values under a max
      send_item(mts_pkg::OP_POP,  32'hffff_ffff);
      send_item(mts_pkg::OP_PUSH, 32'h8000_0000);
      send_item(mts_pkg::OP_PUSH, 32'h8000_0000);
      send_item(mts_pkg::OP_PUSH, 32'h7fff_ffff);
      send_item(mts_pkg::OP_PUSH, 32'h7fff_ffff);
      send_item(mts_pkg::OP_PUSH, 32'h0000_0000);
      send_item(mts_pkg::OP_PUSH, 32'hffff_ffff);
      repeat (7) send_item(mts_pkg::OP_POP, 32'ha5a5_5a5a);
      send_item(mts_pkg::OP_POP,  32'h0000_0000);
      send_item(mts_pkg::OP_PUSH, 32'd5);
      send_item(mts_pkg::OP_PUSH, 32'd3);
      send_item(mts_pkg::OP_PUSH, 32'd5);
      repeat (4) send_item(mts_pkg::OP_POP, $urandom);

      // random segments with varying push/pop mix and sender idling
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0:       push_pct = 25;
            1:       push_pct = 50;
            2:       push_pct = 75;
            default: push_pct = 95;
         endcase
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 25;
            default: gap_pct = 60;
         endcase
         repeat (seg_len) begin
            if ($urandom_range(1, 100) <= push_pct)
               send_item(mts_pkg::OP_PUSH, pick_value());
            else
               send_item(mts_pkg::OP_POP, $urandom);
            sent++;
         end
      end

      // drain to empty, then pop on empty
      gap_pct = 10;
      while (shadow.depth_n > 0)
         send_item(mts_pkg::OP_POP, $urandom);
      repeat (2) send_item(mts_pkg::OP_POP, $urandom);
      req_tvalid <= 1'b0;

      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d pushes (%0d refused as full) and %0d pops (%0d on empty)",
               shadow.n_push, shadow.n_full, shadow.n_pop, shadow.n_empty);
      $display("%0d responses checked, deepest stack %0d, up to %0d distinct maxima",
               shadow.n_checked, shadow.deepest, shadow.most_peaks);
      if (shadow.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
